/* rtl/core/xmodem_checksum_receiver_unit_assert.svh */
// assertion macros for the xmodem checksum receiver
// used by the top level only; no other dependencies
`ifndef XMODEM_CHECKSUM_RECEIVER_UNIT_ASSERT_SVH
`define XMODEM_CHECKSUM_RECEIVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising clock edge out of reset
`define XCR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define XCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define XCR_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define XCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/core/xcr_pkg.sv */
// shared types and constants of the xmodem checksum receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package xcr_pkg;

   // frame geometry
   localparam int PACKET_BYTES = 128;
   localparam int WORD_COUNT   = PACKET_BYTES / 4;
   localparam int WORD_IDX_W   = $clog2(WORD_COUNT);
   localparam int BYTE_IDX_W   = $clog2(PACKET_BYTES);

   // protocol bytes
   localparam logic [7:0] BYTE_SOH = 8'h01;
   localparam logic [7:0] BYTE_EOT = 8'h04;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_CAN = 8'h18;

   // register reset values
   localparam logic [31:0] VERSION_NONE   = 32'hFFFF_FFFF;
   localparam logic [31:0] BASE_ADDR_RST  = 32'h0802_0000;

   // result kinds
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_REPLY = 3'd0;
   localparam kind_type KIND_WRITE = 3'd1;
   localparam kind_type KIND_ERASE = 3'd2;
   localparam kind_type KIND_DONE  = 3'd3;
   localparam kind_type KIND_ABORT = 3'd4;

   // input item codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // configuration register indexes
   typedef logic csr_index_type;
   localparam csr_index_type CSR_CURRENT_VERSION = 1'b0;
   localparam csr_index_type CSR_STORE_BASE      = 1'b1;

   // controller states
   typedef enum logic [3:0] {
      S_SOH,
      S_BLOCK,
      S_COMPL,
      S_DATA,
      S_CHECK,
      S_NAK,
      S_ERASE,
      S_WRITE,
      S_ACK,
      S_CAN1,
      S_CAN2,
      S_CAN3,
      S_ABORT,
      S_EOT_ACK,
      S_DONE,
      S_STOP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       start_xfer;
      logic       begin_frame;
      logic       take_data;
      logic       mark_version;
      logic       word_step;
      logic       advance;
      kind_type   kind;
      logic [7:0] reply;
      logic       last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_soh;
      logic is_eot;
      logic blk_ok;
      logic cmp_ok;
      logic sum_ok;
      logic version_ok;
      logic sector_cross;
      logic data_last;
      logic word_last;
      logic started;
   } status_type;

endpackage
`default_nettype wire

/* rtl/core/xcr_req_if.sv */
// input channel of the xmodem checksum receiver: bytes and ticks
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface xcr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink (input valid, input op, input rx_byte, output ready);
endinterface
`default_nettype wire

/* rtl/core/xcr_rsp_if.sv */
// result channel of the xmodem checksum receiver
// depends on xcr_pkg
`timescale 1ns / 1ps
`default_nettype none
interface xcr_rsp_if;
   logic              valid;
   logic              ready;
   xcr_pkg::kind_type kind;
   logic [7:0]        reply_byte;
   logic [31:0]       address;
   logic [31:0]       data_word;
   logic              last;

   modport source (output valid, output kind, output reply_byte, output address,
                   output data_word, output last, input ready);
   modport sink (input valid, input kind, input reply_byte, input address,
                 input data_word, input last, output ready);
endinterface
`default_nettype wire

/* rtl/core/xmodem_checksum_receiver_unit.sv */
// top level of the xmodem checksum receiver
// depends on xcr_pkg, xcr_req_if, xcr_rsp_if, xcr_ctrl, xcr_datapath and the assert header
//
//   channel   dir  handshake       payload
//   req_chan  in   valid / ready   op, rx_byte
//   rsp_chan  out  valid / ready   kind, reply_byte, address, data_word, last
//   csr_*     in   write enable    csr_index, csr_write_data
//
// a good frame's checksum byte gives 33 or 34 results, one per cycle while
// rsp_chan is ready, an abort gives 4 and eot gives 2. no item is taken while
// results are pending; a stalled result holds. reset is synchronous; the packet
// memory is not cleared, every word is written before it is read.
`timescale 1ns / 1ps
`default_nettype none
`include "xmodem_checksum_receiver_unit_assert.svh"
module xmodem_checksum_receiver_unit #(
   parameter int SECTOR_BYTES = 16384
) (
   input  wire                    clock,
   input  wire                    reset,
   xcr_req_if.sink                req_chan,
   xcr_rsp_if.source              rsp_chan,
   input  wire                    csr_write_en,
   input  xcr_pkg::csr_index_type csr_index,
   input  wire  [31:0]            csr_write_data
);
   import xcr_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       rsp_fire;
   logic       abort_fire;
   logic       write_fire;

   // frame controller
   xcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   xcr_datapath #(
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .rx_byte        (req_chan.rx_byte),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .kind           (rsp_chan.kind),
      .reply_byte     (rsp_chan.reply_byte),
      .address        (rsp_chan.address),
      .data_word      (rsp_chan.data_word),
      .last           (rsp_chan.last)
   );

   // checks
   assign rsp_fire   = rsp_chan.valid && rsp_chan.ready;
   assign abort_fire = rsp_fire && (rsp_chan.kind == KIND_ABORT);
   assign write_fire = rsp_fire && (rsp_chan.kind == KIND_WRITE);

   `XCR_ASSERT_SAME(a_no_overlap, clock, reset, rsp_chan.valid, !req_chan.ready, "item taken early")
   `XCR_ASSERT_NEXT(a_stop_after_abort, clock, reset, abort_fire, !rsp_chan.valid, "result after abort")
   `XCR_ASSERT_NEXT(a_burst_continues, clock, reset, write_fire, rsp_chan.valid, "word burst broken")

endmodule
`default_nettype wire

/* rtl/core/xcr_ctrl.sv */
// frame controller of the xmodem checksum receiver
// depends on xcr_pkg; drives the datapath by command, reads its status
`timescale 1ns / 1ps
`default_nettype none
module xcr_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_op,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   input  xcr_pkg::status_type status,
   output xcr_pkg::cmd_type    cmd
);
   import xcr_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      req_fire;
   logic      byte_fire;
   logic      rsp_fire;

   // handshake
   always_comb begin
      req_ready = (state_ff == S_SOH) || (state_ff == S_BLOCK) || (state_ff == S_COMPL) ||
                  (state_ff == S_DATA) || (state_ff == S_CHECK) || (state_ff == S_STOP);
      rsp_valid = !req_ready;
   end

   assign req_fire  = req_valid && req_ready;
   assign byte_fire = req_fire && (req_op == OP_BYTE);
   assign rsp_fire  = rsp_valid && rsp_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SOH;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_SOH: begin
            if (req_fire && (req_op == OP_TICK)) begin
               if (!status.started) state_in = S_NAK;
            end else if (byte_fire) begin
               if (status.is_soh) state_in = S_BLOCK;
               else if (status.is_eot) state_in = S_EOT_ACK;
            end
         end
         S_BLOCK: begin
            if (byte_fire) state_in = status.blk_ok ? S_COMPL : S_CAN1;
         end
         S_COMPL: begin
            if (byte_fire) state_in = status.cmp_ok ? S_DATA : S_CAN1;
         end
         S_DATA: begin
            if (byte_fire && status.data_last) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (byte_fire) begin
               priority if (!status.sum_ok) state_in = S_NAK;
               else if (!status.version_ok) state_in = S_CAN1;
               else if (status.sector_cross) state_in = S_ERASE;
               else state_in = S_WRITE;
            end
         end
         S_NAK:     if (rsp_fire) state_in = S_SOH;
         S_ERASE:   if (rsp_fire) state_in = S_WRITE;
         S_WRITE:   if (rsp_fire && status.word_last) state_in = S_ACK;
         S_ACK:     if (rsp_fire) state_in = S_SOH;
         S_CAN1:    if (rsp_fire) state_in = S_CAN2;
         S_CAN2:    if (rsp_fire) state_in = S_CAN3;
         S_CAN3:    if (rsp_fire) state_in = S_ABORT;
         S_ABORT:   if (rsp_fire) state_in = S_STOP;
         S_EOT_ACK: if (rsp_fire) state_in = S_DONE;
         S_DONE:    if (rsp_fire) state_in = S_STOP;
         S_STOP:    state_in = S_STOP;
         default:   state_in = S_STOP;
      endcase
   end

   // commands and result fields
   always_comb begin
      cmd              = '0;
      cmd.kind         = KIND_REPLY;
      cmd.start_xfer   = (state_ff == S_SOH) && byte_fire && status.is_soh;
      cmd.begin_frame  = (state_ff == S_COMPL) && byte_fire;
      cmd.take_data    = (state_ff == S_DATA) && byte_fire;
      cmd.mark_version = (state_ff == S_CHECK) && byte_fire && status.sum_ok;
      cmd.word_step    = (state_ff == S_WRITE) && rsp_fire;
      cmd.advance      = (state_ff == S_ACK) && rsp_fire;
      unique case (state_ff)
         S_NAK: begin
            cmd.reply = BYTE_NAK;
            cmd.last  = 1'b1;
         end
         S_ERASE:   cmd.kind  = KIND_ERASE;
         S_WRITE:   cmd.kind  = KIND_WRITE;
         S_ACK: begin
            cmd.reply = BYTE_ACK;
            cmd.last  = 1'b1;
         end
         S_CAN1, S_CAN2, S_CAN3: cmd.reply = BYTE_CAN;
         S_ABORT: begin
            cmd.kind = KIND_ABORT;
            cmd.last = 1'b1;
         end
         S_EOT_ACK: cmd.reply = BYTE_ACK;
         S_DONE: begin
            cmd.kind = KIND_DONE;
            cmd.last = 1'b1;
         end
         default: cmd.kind = KIND_REPLY;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/core/xcr_datapath.sv */
// datapath of the xmodem checksum receiver: registers, packet memory,
// checksum, addressing and result fields; depends on xcr_pkg
`timescale 1ns / 1ps
`default_nettype none
module xcr_datapath #(
   parameter int SECTOR_BYTES = 16384
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  [7:0]             rx_byte,
   input  wire                    csr_write_en,
   input  xcr_pkg::csr_index_type csr_index,
   input  wire  [31:0]            csr_write_data,
   input  xcr_pkg::cmd_type       cmd,
   output xcr_pkg::status_type    status,
   output xcr_pkg::kind_type      kind,
   output logic [7:0]             reply_byte,
   output logic [31:0]            address,
   output logic [31:0]            data_word,
   output logic                   last
);
   import xcr_pkg::*;

   localparam logic [31:0] SECTOR_MASK = ~(32'(SECTOR_BYTES) - 32'd1);

   logic [31:0]           version_ff;
   logic [31:0]           waddr_ff;
   logic [31:0]           waddr_in;
   logic [7:0]            expected_ff;
   logic                  started_ff;
   logic                  checked_ff;
   logic [BYTE_IDX_W-1:0] byte_idx_ff;
   logic [7:0]            sum_ff;
   logic [31:0]           shift_ff;
   logic [31:0]           word0_ff;
   logic [WORD_IDX_W-1:0] word_cnt_ff;
   logic [WORD_IDX_W-1:0] word_cnt_in;
   logic [31:0]           rd_data_ff;
   logic [31:0]           words_mem [WORD_COUNT];
   logic [31:0]           full_word;
   logic [31:0]           next_addr;

   assign full_word   = {rx_byte, shift_ff[31:8]};
   assign next_addr   = waddr_ff + 32'(PACKET_BYTES);
   assign word_cnt_in = cmd.word_step ? word_cnt_ff + 1'b1 : word_cnt_ff;

   // configuration registers and write address
   always_comb begin
      waddr_in = waddr_ff;
      if (cmd.advance) waddr_in = next_addr;
      else if (csr_write_en && (csr_index == CSR_STORE_BASE) && !started_ff)
         waddr_in = csr_write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_NONE;
         waddr_ff   <= BASE_ADDR_RST;
      end else begin
         waddr_ff <= waddr_in;
         if (csr_write_en && (csr_index == CSR_CURRENT_VERSION))
            version_ff <= csr_write_data;
      end
   end

   // transfer progress
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= 8'd1;
         started_ff  <= 1'b0;
         checked_ff  <= 1'b0;
         byte_idx_ff <= '0;
         sum_ff      <= '0;
         word_cnt_ff <= '0;
      end else begin
         if (cmd.advance) expected_ff <= expected_ff + 8'd1;
         if (cmd.start_xfer) started_ff <= 1'b1;
         if (cmd.mark_version) checked_ff <= 1'b1;
         if (cmd.begin_frame) begin
            byte_idx_ff <= '0;
            sum_ff      <= '0;
         end else if (cmd.take_data) begin
            byte_idx_ff <= byte_idx_ff + 1'b1;
            sum_ff      <= sum_ff + rx_byte;
         end
         word_cnt_ff <= word_cnt_in;
      end
   end

   // little-endian word assembly
   always_ff @(posedge clock) begin
      if (cmd.take_data) begin
         shift_ff <= full_word;
         if (byte_idx_ff == BYTE_IDX_W'(3)) word0_ff <= full_word;
      end
   end

   // packet memory: one word written per four bytes, read one ahead of the burst
   always_ff @(posedge clock) begin
      if (cmd.take_data && (byte_idx_ff[1:0] == 2'b11))
         words_mem[byte_idx_ff[BYTE_IDX_W-1:2]] <= full_word;
      rd_data_ff <= words_mem[word_cnt_in];
   end

   // status to the controller
   always_comb begin
      status.is_soh       = (rx_byte == BYTE_SOH);
      status.is_eot       = (rx_byte == BYTE_EOT);
      status.blk_ok       = (rx_byte == expected_ff);
      status.cmp_ok       = (rx_byte == ~expected_ff);
      status.sum_ok       = (rx_byte == sum_ff);
      status.version_ok   = checked_ff || (version_ff == VERSION_NONE) ||
                            (word0_ff > version_ff);
      status.sector_cross = ((waddr_ff ^ next_addr) & SECTOR_MASK) != 32'd0;
      status.data_last    = (byte_idx_ff == BYTE_IDX_W'(PACKET_BYTES - 1));
      status.word_last    = (word_cnt_ff == WORD_IDX_W'(WORD_COUNT - 1));
      status.started      = started_ff;
   end

   // result fields
   always_comb begin
      kind       = cmd.kind;
      reply_byte = cmd.reply;
      last       = cmd.last;
      address    = 32'd0;
      data_word  = 32'd0;
      if (cmd.kind == KIND_WRITE) begin
         address   = waddr_ff + {{(32 - WORD_IDX_W - 2){1'b0}}, word_cnt_ff, 2'b00};
         data_word = rd_data_ff;
      end else if (cmd.kind == KIND_ERASE) begin
         address = next_addr;
      end
   end

endmodule
`default_nettype wire
